### rtl/rcfe_pkg.sv
// Package for the RC channel frame encoder: shared types, frame constants,
// failsafe widths and the CRC-8 step function. Depends on nothing.
`timescale 1ns / 1ps

package rcfe_pkg;

  // Channel counts and frame geometry.
  localparam int STORED_CHANNELS = 8;
  localparam int FRAME_CHANNELS  = 16;
  localparam int FRAME_BYTES     = 26;
  localparam int PAYLOAD_BYTES   = 22;
  localparam int CRSF_W          = 11;
  localparam int WIDTH_W         = 12;

  // Fixed header bytes.
  localparam logic [7:0] FRAME_LENGTH = 8'd24;
  localparam logic [7:0] FRAME_TYPE   = 8'h16;
  localparam logic [7:0] CRC_POLY     = 8'hD5;

  // Byte positions inside one frame.
  localparam logic [4:0] BYTE_ADDR    = 5'd0;
  localparam logic [4:0] BYTE_LEN     = 5'd1;
  localparam logic [4:0] BYTE_TYPE    = 5'd2;
  localparam logic [4:0] BYTE_PAYLOAD = 5'd3;
  localparam logic [4:0] BYTE_CRC     = 5'd25;

  // Clamp window and mapping endpoints, all in microseconds or frame units.
  localparam logic [WIDTH_W-1:0] CLAMP_LOW_US  = 12'd800;
  localparam logic [WIDTH_W-1:0] CLAMP_HIGH_US = 12'd2200;
  localparam logic [WIDTH_W-1:0] MAP_LOW_US    = 12'd988;
  localparam logic [WIDTH_W-1:0] MAP_HIGH_US   = 12'd2012;
  localparam logic [CRSF_W-1:0]  CRSF_LOW      = 11'd172;
  localparam logic [CRSF_W-1:0]  CRSF_HIGH     = 11'd1811;
  localparam logic [CRSF_W-1:0]  CRSF_SPAN     = 11'd1639;
  // Frame value of a 1500 us width, used for channels without an input.
  localparam logic [CRSF_W-1:0]  CRSF_MID      = 11'd992;

  localparam logic [9:0] AGE_MAX = 10'd1023;

  // Failsafe widths, one per stored channel.
  typedef logic [STORED_CHANNELS-1:0][WIDTH_W-1:0] width_vec_t;
  localparam width_vec_t FAIL_US = {
    12'd1500, 12'd1500, 12'd1500, 12'd900,
    12'd1500, 12'd988,  12'd1500, 12'd1500
  };

  // Link status codes.
  localparam logic [1:0] LINK_NO_DATA  = 2'd0;
  localparam logic [1:0] LINK_DEFAULTS = 2'd1;
  localparam logic [1:0] LINK_ARMED    = 2'd2;
  localparam logic [1:0] LINK_COMMAND  = 2'd3;

  // Input modes.
  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_PERIOD    = 3'd1;
  localparam logic [2:0] CFG_ARM_LOW   = 3'd2;
  localparam logic [2:0] CFG_ARM_HIGH  = 3'd3;
  localparam logic [2:0] CFG_TOLERANCE = 3'd4;
  localparam logic [2:0] CFG_ADDRESS   = 3'd5;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEND
  } seq_state_t;

  // What one channel lane reports to the merge logic.
  typedef struct packed {
    logic [CRSF_W-1:0] crsf;
    logic              near_default;
  } lane_res_t;

  // Frame request from the sequencer to the serializer.
  typedef struct packed {
    logic                           start;
    logic [1:0]                     status;
    logic [7:0]                     address;
    logic [PAYLOAD_BYTES-1:0][7:0]  payload;
  } frame_req_t;

  // One byte of CRC-8, MSB first, init handled by the caller.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/rc_channel_frame_encoder_core.sv
// Top level of the RC channel frame encoder: configuration, link tracking,
// eight channel lanes and the frame serializer. Uses rcfe_pkg, rcfe_lane, rcfe_frame.
//
//   Channel   Direction  Handshake             Beat
//   in        input      in_valid / in_ready   mode and eight channel widths
//   out       output     out_valid / out_ready one frame byte, last flag, status
//   cfg       input      cfg_we                register index and write data
//
// A packet, or a tick that sends no frame, leaves the sequencer idle. A tick that
// sends a frame holds the input through ST_CALC, which settles the lanes into the
// frame request, and ST_SEND: one byte per cycle through the serializer's output
// register. A stalled output stretches the frame by the stall; the last byte may
// still wait while the next beat is taken. Reset loads the failsafe widths at once.
`timescale 1ns / 1ps

module rc_channel_frame_encoder_core #(
  parameter int INPUT_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [15:0] channel_0_us,
  input  logic signed [15:0] channel_1_us,
  input  logic signed [15:0] channel_2_us,
  input  logic signed [15:0] channel_3_us,
  input  logic signed [15:0] channel_4_us,
  input  logic signed [15:0] channel_5_us,
  input  logic signed [15:0] channel_6_us,
  input  logic signed [15:0] channel_7_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         frame_byte,
  output logic               last_byte,
  output logic [1:0]         link_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  localparam int NCH = rcfe_pkg::STORED_CHANNELS;

  // Configuration registers.
  logic [9:0]  timeout_ticks;
  logic [7:0]  send_period_ticks;
  logic [11:0] arm_low_us;
  logic [11:0] arm_high_us;
  logic [7:0]  default_tolerance_us;
  logic [7:0]  frame_address;

  // Link state.
  rcfe_pkg::width_vec_t widths;
  logic [9:0]           link_age;
  logic                 ever_received;
  logic [7:0]           send_count;
  logic                 lost;

  rcfe_pkg::seq_state_t state, state_next;

  logic signed [15:0]                     raw_us  [NCH];
  logic [rcfe_pkg::WIDTH_W-1:0]           clamped [NCH];
  rcfe_pkg::lane_res_t                    lane_res[NCH];
  logic [rcfe_pkg::FRAME_CHANNELS*rcfe_pkg::CRSF_W-1:0] packed_ch;
  logic [NCH-1:0]                         near;

  logic       accept;
  logic       tick;
  logic [9:0] age_inc;
  logic       lost_now;
  logic [8:0] count_inc;
  logic       send_now;
  logic       armed;
  logic       defaults;
  logic       frame_busy;
  logic       frame_start;
  logic [1:0] frame_status;

  rcfe_pkg::frame_req_t req;

  assign raw_us[0] = channel_0_us;
  assign raw_us[1] = channel_1_us;
  assign raw_us[2] = channel_2_us;
  assign raw_us[3] = channel_3_us;
  assign raw_us[4] = channel_4_us;
  assign raw_us[5] = channel_5_us;
  assign raw_us[6] = channel_6_us;
  assign raw_us[7] = channel_7_us;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks        <= 10'd500;
      send_period_ticks    <= 8'd20;
      arm_low_us           <= 12'd1000;
      arm_high_us          <= 12'd1200;
      default_tolerance_us <= 8'd10;
      frame_address        <= 8'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcfe_pkg::CFG_TIMEOUT:   timeout_ticks        <= cfg_data[9:0];
        rcfe_pkg::CFG_PERIOD:    send_period_ticks    <= cfg_data[7:0];
        rcfe_pkg::CFG_ARM_LOW:   arm_low_us           <= cfg_data;
        rcfe_pkg::CFG_ARM_HIGH:  arm_high_us          <= cfg_data;
        rcfe_pkg::CFG_TOLERANCE: default_tolerance_us <= cfg_data[7:0];
        rcfe_pkg::CFG_ADDRESS:   frame_address        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Channel lanes, one per stored width.
  for (genvar i = 0; i < NCH; i++) begin : g_lane
    rcfe_lane #(
      .FAIL_WIDTH(rcfe_pkg::FAIL_US[i])
    ) u_lane (
      .raw_us   (raw_us[i]),
      .width    (widths[i]),
      .tolerance(default_tolerance_us),
      .clamped  (clamped[i]),
      .res      (lane_res[i])
    );
    // The arm switch channel takes no part in the defaults check.
    if (i == 4) begin : g_arm
      assign near[i] = 1'b1;
    end else begin : g_chk
      assign near[i] = lane_res[i].near_default;
    end
  end

  // Merge: pack sixteen frame channels LSB first.
  for (genvar i = 0; i < rcfe_pkg::FRAME_CHANNELS; i++) begin : g_pack
    if (i < INPUT_CHANNELS && i < NCH) begin : g_live
      assign packed_ch[i*rcfe_pkg::CRSF_W +: rcfe_pkg::CRSF_W] = lane_res[i].crsf;
    end else begin : g_fixed
      assign packed_ch[i*rcfe_pkg::CRSF_W +: rcfe_pkg::CRSF_W] = rcfe_pkg::CRSF_MID;
    end
  end

  // Merge: link status from the stored widths.
  assign armed    = (widths[4] >= arm_low_us) && (widths[4] <= arm_high_us);
  assign defaults = &near;

  always_comb begin
    if (lost) begin
      frame_status = rcfe_pkg::LINK_NO_DATA;
    end else if (defaults && !armed) begin
      frame_status = rcfe_pkg::LINK_DEFAULTS;
    end else if (defaults) begin
      frame_status = rcfe_pkg::LINK_ARMED;
    end else begin
      frame_status = rcfe_pkg::LINK_COMMAND;
    end
  end

  assign req = {frame_start, frame_status, frame_address, packed_ch};

  // Tick arithmetic.
  assign accept    = in_valid && in_ready;
  assign tick      = (mode == rcfe_pkg::MODE_TICK);
  assign age_inc   = (link_age == rcfe_pkg::AGE_MAX) ? link_age : link_age + 10'd1;
  assign lost_now  = !ever_received || (age_inc > timeout_ticks);
  assign count_inc = {1'b0, send_count} + 9'd1;
  assign send_now  = (count_inc >= {1'b0, send_period_ticks});

  // Link state update on accepted beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      widths        <= rcfe_pkg::FAIL_US;
      link_age      <= '0;
      ever_received <= 1'b0;
      send_count    <= '0;
      lost          <= 1'b1;
    end else if (accept) begin
      if (!tick) begin
        for (int i = 0; i < NCH; i++) begin
          widths[i] <= clamped[i];
        end
        link_age      <= '0;
        ever_received <= 1'b1;
      end else begin
        link_age <= age_inc;
        if (lost_now) begin
          widths <= rcfe_pkg::FAIL_US;
        end
        lost       <= lost_now;
        send_count <= send_now ? 8'd0 : count_inc[7:0];
      end
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rcfe_pkg::ST_IDLE: begin
        if (accept && tick && send_now) begin
          state_next = rcfe_pkg::ST_CALC;
        end
      end
      rcfe_pkg::ST_CALC: state_next = rcfe_pkg::ST_SEND;
      rcfe_pkg::ST_SEND: begin
        if (!frame_busy) begin
          state_next = rcfe_pkg::ST_IDLE;
        end
      end
      default: state_next = rcfe_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    frame_start = 1'b0;
    unique case (state)
      rcfe_pkg::ST_IDLE: in_ready    = 1'b1;
      rcfe_pkg::ST_CALC: frame_start = 1'b1;
      rcfe_pkg::ST_SEND: ;
      default: ;
    endcase
  end

  rcfe_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .busy       (frame_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .link_status(link_status)
  );

endmodule

### rtl/rcfe_lane.sv
// One channel lane: clamps an incoming width, maps the stored width to the
// 11-bit frame value and checks it against its failsafe width. Uses rcfe_pkg.
`timescale 1ns / 1ps

module rcfe_lane #(
  parameter logic [11:0] FAIL_WIDTH = 12'd1500
) (
  input  logic signed [15:0]            raw_us,
  input  logic [rcfe_pkg::WIDTH_W-1:0]  width,
  input  logic [7:0]                    tolerance,
  output logic [rcfe_pkg::WIDTH_W-1:0]  clamped,
  output rcfe_pkg::lane_res_t           res
);

  logic [9:0]                  offset;
  logic [20:0]                 scaled;
  logic [11:0]                 deviation;
  logic [rcfe_pkg::CRSF_W-1:0] crsf;
  logic                        near_default;

  // Clamp the signed packet width into the legal window.
  always_comb begin
    if (raw_us < $signed({4'd0, rcfe_pkg::CLAMP_LOW_US})) begin
      clamped = rcfe_pkg::CLAMP_LOW_US;
    end else if (raw_us > $signed({4'd0, rcfe_pkg::CLAMP_HIGH_US})) begin
      clamped = rcfe_pkg::CLAMP_HIGH_US;
    end else begin
      clamped = raw_us[11:0];
    end
  end

  // Linear map with rounding; the offset fits ten bits inside the open range.
  assign offset = 10'(width - rcfe_pkg::MAP_LOW_US);
  assign scaled = 21'(offset) * 21'(rcfe_pkg::CRSF_SPAN) + 21'd512;

  always_comb begin
    if (width <= rcfe_pkg::MAP_LOW_US) begin
      crsf = rcfe_pkg::CRSF_LOW;
    end else if (width >= rcfe_pkg::MAP_HIGH_US) begin
      crsf = rcfe_pkg::CRSF_HIGH;
    end else begin
      crsf = rcfe_pkg::CRSF_LOW + scaled[20:10];
    end
  end

  // Absolute distance from the failsafe width.
  assign deviation = (width >= FAIL_WIDTH) ? (width - FAIL_WIDTH) : (FAIL_WIDTH - width);
  assign near_default = (deviation <= {4'd0, tolerance});

  assign res = {crsf, near_default};

endmodule

### rtl/rcfe_frame.sv
// Frame serializer: latches one frame request and sends its 26 bytes through
// an output register, folding the CRC-8 in as bytes go out. Uses rcfe_pkg.
`timescale 1ns / 1ps

module rcfe_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  rcfe_pkg::frame_req_t  req,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            frame_byte,
  output logic                  last_byte,
  output logic [1:0]            link_status
);

  logic [4:0]                                 idx;
  logic [7:0]                                 crc;
  logic [7:0]                                 address;
  logic [1:0]                                 status;
  logic [rcfe_pkg::PAYLOAD_BYTES-1:0][7:0]    payload;
  logic [4:0]                                 pidx;
  logic [7:0]                                 byte_next;
  logic                                       load;

  assign load = busy && (!out_valid || out_ready);
  assign pidx = idx - rcfe_pkg::BYTE_PAYLOAD;

  // Pick the byte at the current position.
  always_comb begin
    if (idx == rcfe_pkg::BYTE_ADDR) begin
      byte_next = address;
    end else if (idx == rcfe_pkg::BYTE_LEN) begin
      byte_next = rcfe_pkg::FRAME_LENGTH;
    end else if (idx == rcfe_pkg::BYTE_TYPE) begin
      byte_next = rcfe_pkg::FRAME_TYPE;
    end else if (idx == rcfe_pkg::BYTE_CRC) begin
      byte_next = crc;
    end else begin
      byte_next = payload[pidx];
    end
  end

  // Control: busy flag, byte position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        idx <= idx + 5'd1;
        if (idx == rcfe_pkg::BYTE_CRC) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: latched request, running CRC and the output beat.
  always_ff @(posedge clk) begin
    if (req.start) begin
      address <= req.address;
      status  <= req.status;
      payload <= req.payload;
      crc     <= 8'd0;
    end else if (load && idx >= rcfe_pkg::BYTE_TYPE && idx < rcfe_pkg::BYTE_CRC) begin
      crc <= rcfe_pkg::crc_step(crc, byte_next);
    end
    if (load) begin
      frame_byte  <= byte_next;
      last_byte   <= (idx == rcfe_pkg::BYTE_CRC);
      link_status <= status;
    end
  end

endmodule
